>>> rtl/fdb_pkg.sv
// fdb_pkg: shared types and constants of the 2x decimating 8-tap FIR.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package fdb_pkg;

    localparam int TAP_COUNT     = 8;
    localparam int SAMPLE_W      = 8;
    localparam int TAP_W         = 8;
    localparam int PROD_W        = 16;
    localparam int ACC_W         = 16;
    localparam int OUT_SHIFT_DEF = 5;
    localparam int TAP_IDX_W     = $clog2(TAP_COUNT);
    localparam int PADDR_W       = TAP_IDX_W + 2;
    localparam int PDATA_W       = 32;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int SEEN_W        = 3;
    localparam int LEFT_W        = 3;

    localparam logic [SEEN_W-1:0]   SEEN_MAX   = 3'd7;
    localparam logic [SEEN_W-1:0]   SEEN_FIRE  = 3'd5;
    localparam logic [LEFT_W-1:0]   PAD_ODD    = 3'd4;
    localparam logic [LEFT_W-1:0]   PAD_EVEN   = 3'd3;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 8'd255;

    typedef logic [TAP_COUNT-1:0][SAMPLE_W-1:0] t_window;
    typedef logic [TAP_COUNT-1:0][TAP_W-1:0]    t_taps;

    localparam t_taps TAP_RESET = {8'd0, 8'd0, 8'd0, 8'd16, 8'd16, 8'd0, 8'd0, 8'd0};

    typedef struct packed {
        logic    bypass;
        logic    last;
        t_window win;
    } t_job;

    typedef enum logic {
        FS_RUN,
        FS_FLUSH
    } t_front_state;

endpackage

>>> rtl/fdb_front.sv
// fdb_front: takes input samples, keeps the sample window and frame position,
// pads the frame end, and issues one filter job per due output. Uses fdb_pkg.
`timescale 1ns / 1ps

module fdb_front
    import fdb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [SAMPLE_W-1:0] i_sample_in,
    input  logic                i_frame_end,
    input  logic                i_space,
    output logic                o_push,
    output t_job                o_job
);

    t_front_state        r_state, n_state;
    t_window             r_win, n_win;
    logic [SEEN_W-1:0]   r_seen, n_seen;
    logic                r_parity, n_parity;
    logic [LEFT_W-1:0]   r_left, n_left;
    logic [SAMPLE_W-1:0] r_hold, n_hold;

    logic                w_take;
    logic [SAMPLE_W-1:0] w_val;
    t_window             w_base;
    t_window             w_shift;
    logic [SEEN_W-1:0]   w_seen_inc;
    logic                w_par;
    logic                w_fire;
    logic                w_single;

    assign w_take     = i_valid && o_ready;
    assign w_val      = (r_state == FS_FLUSH) ? r_hold : i_sample_in;
    assign w_single   = (r_seen == '0) && i_frame_end;
    assign w_base     = (r_state == FS_RUN && r_seen == '0) ? {TAP_COUNT{i_sample_in}} : r_win;
    assign w_shift    = {w_val, w_base[TAP_COUNT-1:1]};
    assign w_seen_inc = (r_seen == SEEN_MAX) ? r_seen : r_seen + SEEN_W'(1);
    assign w_par      = ~r_parity;
    assign w_fire     = w_par && (w_seen_inc >= SEEN_FIRE);

    always_comb begin
        n_state  = r_state;
        n_win    = r_win;
        n_seen   = r_seen;
        n_parity = r_parity;
        n_left   = r_left;
        n_hold   = r_hold;
        case (r_state)
            FS_RUN: begin
                if (w_take) begin
                    if (w_single) begin
                        n_seen   = '0;
                        n_parity = 1'b0;
                    end else begin
                        n_win    = w_shift;
                        n_seen   = w_seen_inc;
                        n_parity = w_par;
                        if (i_frame_end) begin
                            n_state = FS_FLUSH;
                            n_left  = w_par ? PAD_ODD : PAD_EVEN;
                            n_hold  = i_sample_in;
                        end
                    end
                end
            end
            FS_FLUSH: begin
                if (i_space) begin
                    n_win    = w_shift;
                    n_seen   = w_seen_inc;
                    n_parity = w_par;
                    n_left   = r_left - LEFT_W'(1);
                    if (r_left == LEFT_W'(1)) begin
                        n_state  = FS_RUN;
                        n_seen   = '0;
                        n_parity = 1'b0;
                    end
                end
            end
            default: begin
                n_state = FS_RUN;
            end
        endcase
    end

    always_comb begin
        o_ready    = 1'b0;
        o_push     = 1'b0;
        o_job      = '0;
        o_job.win  = w_shift;
        case (r_state)
            FS_RUN: begin
                o_ready = i_space;
                if (w_take) begin
                    if (w_single) begin
                        o_push       = 1'b1;
                        o_job.bypass = 1'b1;
                        o_job.last   = 1'b1;
                        o_job.win    = {TAP_COUNT{i_sample_in}};
                    end else begin
                        o_push = w_fire;
                    end
                end
            end
            FS_FLUSH: begin
                if (i_space) begin
                    o_push     = w_fire || (r_left == LEFT_W'(1));
                    o_job.last = (r_left == LEFT_W'(1));
                end
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= FS_RUN;
            r_win    <= '0;
            r_seen   <= '0;
            r_parity <= 1'b0;
            r_left   <= '0;
        end else begin
            r_state  <= n_state;
            r_win    <= n_win;
            r_seen   <= n_seen;
            r_parity <= n_parity;
            r_left   <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold <= n_hold;
    end

endmodule

>>> rtl/fdb_queue.sv
// fdb_queue: short job queue between the front and the back of the FIR.
// Uses fdb_pkg for the job type and depth.
`timescale 1ns / 1ps

module fdb_queue
    import fdb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_space,
    output logic o_valid,
    output t_job o_job,
    input  logic i_pop
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_count;

    assign o_space = (r_count != (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (QPTR_W + 1)'(1);
                2'b01:   r_count <= r_count - (QPTR_W + 1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> rtl/fdb_back.sv
// fdb_back: two-stage filter datapath: tap products, then sum, round,
// shift and clamp (or pass a bypass job's sample) into the output register. Uses fdb_pkg.
`timescale 1ns / 1ps

module fdb_back
    import fdb_pkg::*;
#(
    parameter int OUT_SHIFT = OUT_SHIFT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_taps               i_taps,
    input  logic                i_valid,
    input  t_job                i_job,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [SAMPLE_W-1:0] o_sample_out,
    output logic                o_final_out
);

    localparam logic [ACC_W-1:0] ROUND = ACC_W'(1) << (OUT_SHIFT - 1);

    logic [TAP_COUNT-1:0][PROD_W-1:0] w_prod;
    logic [TAP_COUNT-1:0][PROD_W-1:0] r_prod;
    logic                             r_s1_valid;
    logic                             r_s1_bypass;
    logic                             r_s1_last;
    logic [SAMPLE_W-1:0]              r_s1_val;
    logic                             r_out_valid;
    logic [SAMPLE_W-1:0]              r_out_data;
    logic                             r_out_last;

    logic                             w_out_adv;
    logic                             w_s1_adv;
    logic [ACC_W-1:0]                 w_acc;
    logic [ACC_W-1:0]                 w_shr;
    logic [SAMPLE_W-1:0]              w_res;

    assign w_out_adv = !r_out_valid || i_ready;
    assign w_s1_adv  = !r_s1_valid || w_out_adv;
    assign o_pop     = i_valid && w_s1_adv;

    always_comb begin
        for (int k = 0; k < TAP_COUNT; k++) begin
            w_prod[k] = PROD_W'($signed(i_taps[k]) * $signed({1'b0, i_job.win[k]}));
        end
    end

    always_comb begin
        w_acc = ROUND;
        for (int k = 0; k < TAP_COUNT; k++) begin
            w_acc = w_acc + r_prod[k];
        end
        w_shr = w_acc >> OUT_SHIFT;
        if (r_s1_bypass) begin
            w_res = r_s1_val;
        end else if (w_acc[ACC_W-1]) begin
            w_res = '0;
        end else if (w_shr > ACC_W'(SAMPLE_MAX)) begin
            w_res = SAMPLE_MAX;
        end else begin
            w_res = w_shr[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_s1_adv) begin
                r_s1_valid <= i_valid;
            end
            if (w_out_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_prod      <= w_prod;
            r_s1_bypass <= i_job.bypass;
            r_s1_last   <= i_job.last;
            r_s1_val    <= i_job.win[TAP_COUNT-1];
        end
        if (w_out_adv && r_s1_valid) begin
            r_out_data <= w_res;
            r_out_last <= r_s1_last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_sample_out = r_out_data;
    assign o_final_out  = r_out_last;

endmodule

>>> rtl/fir_decimate_by_two_u8_top.sv
// fir_decimate_by_two_u8_top: 2x decimating 8-tap FIR, APB taps; uses fdb_front,
// fdb_queue, fdb_back and fdb_pkg. Reset: taps 0 but tap3 = tap4 = 16, all empty.
// A result is registered in the job queue, the product register and the output
// register; padded results at a frame end take the same path. Throughput: one
// sample per cycle; a frame end holds off input while 3 or 4 copies of its last
// sample pad the frame, and a full job queue holds it off until the back drains.
`timescale 1ns / 1ps

module fir_decimate_by_two_u8_top
    import fdb_pkg::*;
#(
    parameter int OUT_SHIFT = OUT_SHIFT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [SAMPLE_W-1:0] i_sample_in,
    input  logic                i_frame_end,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [SAMPLE_W-1:0] o_sample_out,
    output logic                o_final_out,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    t_taps                r_taps;
    logic [TAP_IDX_W-1:0] w_idx;
    logic                 w_push;
    t_job                 w_push_job;
    logic                 w_space;
    logic                 w_q_valid;
    t_job                 w_q_job;
    logic                 w_pop;

    assign w_idx  = paddr[PADDR_W-1:2];
    assign pready = 1'b1;
    assign prdata = PDATA_W'(r_taps[w_idx]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taps <= TAP_RESET;
        end else if (psel && penable && pwrite && pready) begin
            r_taps[w_idx] <= pwdata[TAP_W-1:0];
        end
    end

    fdb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_sample_in (i_sample_in),
        .i_frame_end (i_frame_end),
        .i_space     (w_space),
        .o_push      (w_push),
        .o_job       (w_push_job)
    );

    fdb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_space (w_space),
        .o_valid (w_q_valid),
        .o_job   (w_q_job),
        .i_pop   (w_pop)
    );

    fdb_back #(
        .OUT_SHIFT (OUT_SHIFT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_taps       (r_taps),
        .i_valid      (w_q_valid),
        .i_job        (w_q_job),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_sample_out (o_sample_out),
        .o_final_out  (o_final_out)
    );

endmodule
